/* hw/rtl/assert_macros.svh */
// Assertion macros used by sva_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, held off while reset is high.
`define SVA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that also runs through reset.
`define SVA_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* hw/rtl/sva_pkg.sv */
// Shared types and constants of the voice allocator.
// No dependencies.
package sva_pkg;

   localparam int NOTE_W          = 7;
   localparam int VEL_W           = 7;
   localparam int AGE_W           = 32;
   localparam int OP_W            = 3;
   localparam int ACT_W           = 3;
   localparam int VOICE_W         = 4;
   localparam int MODE_W          = 2;
   localparam int MAX_RESULTS     = 18;
   localparam int RES_CNT_W       = 5;
   localparam int VOICES_DEF      = 16;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [VEL_W-1:0] REPLAY_VEL = 7'd13;

   // request op codes
   localparam logic [OP_W-1:0] OP_NOTE_ON    = 3'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF   = 3'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF    = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK       = 3'd3;
   localparam logic [OP_W-1:0] OP_VOICE_DONE = 3'd4;

   // response action codes
   localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RETUNE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RESTART = 3'd3;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_GTRIG   = 3'd5;
   localparam logic [ACT_W-1:0] ACT_GREL    = 3'd6;

   // voice states
   localparam logic [1:0] VS_UNUSED    = 2'd0;
   localparam logic [1:0] VS_PLAYING   = 2'd1;
   localparam logic [1:0] VS_RELEASING = 2'd2;

   // voice mode register values
   localparam logic [MODE_W-1:0] MODE_POLY    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RETUNE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]        vstate;
      logic [NOTE_W-1:0] key;
      logic [AGE_W-1:0]  age;
   } voice_entry_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [VOICE_W-1:0] voice;
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   velocity;
   } result_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_VRD   = 11'b000_0000_0010,
      ST_VEV   = 11'b000_0000_0100,
      ST_ACT   = 11'b000_0000_1000,
      ST_GTRIG = 11'b000_0001_0000,
      ST_PUSH  = 11'b000_0010_0000,
      ST_KRD   = 11'b000_0100_0000,
      ST_KEV   = 11'b000_1000_0000,
      ST_NDEC  = 11'b001_0000_0000,
      ST_GREL  = 11'b010_0000_0000,
      ST_FIN   = 11'b100_0000_0000
   } fsm_type;

   typedef enum logic [1:0] {
      VSCAN_FIND,
      VSCAN_REL,
      VSCAN_TICK,
      VSCAN_DONE
   } vscan_type;

   typedef enum logic [1:0] {
      KSCAN_SEARCH,
      KSCAN_SHIFT,
      KSCAN_TOP
   } kscan_type;

endpackage

/* hw/rtl/sva_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* hw/rtl/synth_voice_allocator_core.sv */
// Voice allocator top level: voice table and key stack sequencer.
// Depends on sva_pkg and sva_ram.
//
// Usage:
//  - csr_wr_en/csr_wr_data write the voice mode (0 poly, 1 mono retune,
//    2 mono restart); write it only while the block is idle.
//  - req_* carries one event (note on/off, all off, tick, voice done) per
//    request, taken when req_valid and req_ready are both high.
//  - rsp_* returns one or more actions per request; rsp_last marks the last.
//    Events with no action return one "none" response. At most 18 are sent.
// Timing: one request at a time. Voice table scans read, then evaluate each voice
//  (the voice RAM has registered read data); a tick, an all-off and a note on
//  with nonzero velocity in modes 0 to 2 scan every voice, and a note off also
//  reads each key stack entry searched or shifted. Voice done reads and
//  evaluates only the named voice.
// Stalls: each action waits in a one-deep holding register so that the last
//  flag can be set; a stalled rsp_ready freezes the scan at the voice that
//  wants to report. The final response sits in the output register while the
//  next request is accepted.
// Reset: voices read as unused, key and age zero (per-voice valid bits), stack empty, mode 0.
module synth_voice_allocator_core #(
   parameter int VOICES      = sva_pkg::VOICES_DEF,
   parameter int STACK_DEPTH = sva_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sva_pkg::MODE_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sva_pkg::OP_W-1:0]      req_op,
   input  logic [sva_pkg::NOTE_W-1:0]    req_note,
   input  logic [sva_pkg::VEL_W-1:0]     req_velocity,
   input  logic [sva_pkg::VOICE_W-1:0]   req_done_voice,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sva_pkg::ACT_W-1:0]     rsp_action,
   output logic [sva_pkg::VOICE_W-1:0]   rsp_voice,
   output logic [sva_pkg::NOTE_W-1:0]    rsp_out_note,
   output logic [sva_pkg::VEL_W-1:0]     rsp_out_velocity,
   output logic                          rsp_last
);
   import sva_pkg::*;

   localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VCW  = $clog2(VOICES + 1);
   localparam int SIW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int KCW  = $clog2(STACK_DEPTH + 1);
   localparam int VE_W = $bits(voice_entry_type);

   // sequencer and config
   fsm_type              fsm_ff, fsm_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   vscan_type            vkind_ff, vkind_in;
   kscan_type            kkind_ff, kkind_in;
   logic [VCW-1:0]       vidx_ff, vidx_in;
   logic [KCW-1:0]       kidx_ff, kidx_in;
   logic [KCW-1:0]       kc_ff, kc_in;
   logic [VOICES-1:0]    vvalid_ff, vvalid_in;

   // request context
   logic [OP_W-1:0]      op_ff, op_in;
   logic [NOTE_W-1:0]    note_ff, note_in;
   logic [NOTE_W-1:0]    wnote_ff, wnote_in;
   logic [VEL_W-1:0]     wvel_ff, wvel_in;
   logic                 replay_ff, replay_in;
   logic                 grel_ff, grel_in;
   logic [NOTE_W-1:0]    grel_note_ff, grel_note_in;
   logic                 rel_all_ff, rel_all_in;

   // scan findings
   logic                 fu_v_ff, fu_v_in;
   logic [VIW-1:0]       fu_idx_ff, fu_idx_in;
   logic                 fp_v_ff, fp_v_in;
   logic [VIW-1:0]       fp_idx_ff, fp_idx_in;
   logic [AGE_W-1:0]     fp_age_ff, fp_age_in;
   logic                 br_v_ff, br_v_in;
   logic [VIW-1:0]       br_idx_ff, br_idx_in;
   logic [AGE_W-1:0]     br_age_ff, br_age_in;
   logic                 ba_v_ff, ba_v_in;
   logic [VIW-1:0]       ba_idx_ff, ba_idx_in;
   logic [AGE_W-1:0]     ba_age_ff, ba_age_in;

   // response path
   logic                 pend_v_ff, pend_v_in;
   result_type           pend_ff, pend_in;
   logic                 out_v_ff, out_v_in;
   result_type           out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   // memory ports
   logic                 vram_we, vram_re;
   logic [VIW-1:0]       vram_waddr, vram_raddr;
   voice_entry_type      vram_wdata;
   logic [VE_W-1:0]      vram_rdata;
   logic                 rdv_ff, rdv_in;
   logic                 kram_we, kram_re;
   logic [SIW-1:0]       kram_waddr, kram_raddr;
   logic [NOTE_W-1:0]    kram_wdata, kram_rdata;

   // emit handshake
   logic                 em_req, em_keep, em_go, fin_req, out_free;
   result_type           em_res;

   voice_entry_type      ve;
   logic [VIW-1:0]       vaddr, pick;
   logic [VIW+VOICE_W-1:0] dv_ext;
   logic [KCW-1:0]       kidx_p1, kc_m1;
   logic                 restart;

   function automatic logic [VOICE_W-1:0] to_vout(input logic [VIW-1:0] i);
      logic [VIW+VOICE_W-1:0] w;
      w = {{VOICE_W{1'b0}}, i};
      return w[VOICE_W-1:0];
   endfunction

   sva_ram #(.WIDTH(VE_W), .DEPTH(VOICES)) u_voice_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_waddr),
      .wr_data (vram_wdata),
      .rd_en   (vram_re),
      .rd_addr (vram_raddr),
      .rd_data (vram_rdata)
   );

   sva_ram #(.WIDTH(NOTE_W), .DEPTH(STACK_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (kram_we),
      .wr_addr (kram_waddr),
      .wr_data (kram_wdata),
      .rd_en   (kram_re),
      .rd_addr (kram_raddr),
      .rd_data (kram_rdata)
   );

   // entries never written read as unused / zero
   assign ve        = rdv_ff ? voice_entry_type'(vram_rdata) : '0;
   assign vaddr     = vidx_ff[VIW-1:0];
   assign dv_ext    = {{VIW{1'b0}}, req_done_voice};
   assign kidx_p1   = kidx_ff + 1'b1;
   assign kc_m1     = kc_ff - 1'b1;
   assign out_free  = !out_v_ff || rsp_ready;
   assign em_keep   = res_cnt_ff < RES_CNT_W'(MAX_RESULTS);
   assign em_go     = !em_req || !em_keep || !pend_v_ff || out_free;
   assign restart   = (mode_ff == MODE_RESTART) && !replay_ff;
   assign pick      = fu_v_ff ? fu_idx_ff : (br_v_ff ? br_idx_ff : ba_idx_ff);

   assign req_ready        = (fsm_ff == ST_IDLE);
   assign rsp_valid        = out_v_ff;
   assign rsp_action       = out_ff.action;
   assign rsp_voice        = out_ff.voice;
   assign rsp_out_note     = out_ff.note;
   assign rsp_out_velocity = out_ff.velocity;
   assign rsp_last         = out_last_ff;

   always_comb begin
      fsm_in       = fsm_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      vkind_in     = vkind_ff;
      kkind_in     = kkind_ff;
      vidx_in      = vidx_ff;
      kidx_in      = kidx_ff;
      kc_in        = kc_ff;
      vvalid_in    = vvalid_ff;
      op_in        = op_ff;
      note_in      = note_ff;
      wnote_in     = wnote_ff;
      wvel_in      = wvel_ff;
      replay_in    = replay_ff;
      grel_in      = grel_ff;
      grel_note_in = grel_note_ff;
      rel_all_in   = rel_all_ff;
      fu_v_in      = fu_v_ff;
      fu_idx_in    = fu_idx_ff;
      fp_v_in      = fp_v_ff;
      fp_idx_in    = fp_idx_ff;
      fp_age_in    = fp_age_ff;
      br_v_in      = br_v_ff;
      br_idx_in    = br_idx_ff;
      br_age_in    = br_age_ff;
      ba_v_in      = ba_v_ff;
      ba_idx_in    = ba_idx_ff;
      ba_age_in    = ba_age_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      res_cnt_in   = res_cnt_ff;
      rdv_in       = rdv_ff;
      vram_we      = 1'b0;
      vram_waddr   = vaddr;
      vram_wdata   = ve;
      vram_re      = 1'b0;
      vram_raddr   = vaddr;
      kram_we      = 1'b0;
      kram_waddr   = kidx_ff[SIW-1:0];
      kram_wdata   = kram_rdata;
      kram_re      = 1'b0;
      kram_raddr   = kidx_ff[SIW-1:0];
      em_req       = 1'b0;
      em_res       = '0;
      fin_req      = 1'b0;

      case (fsm_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               note_in    = req_note;
               wnote_in   = req_note;
               wvel_in    = req_velocity;
               res_cnt_in = '0;
               replay_in  = 1'b0;
               grel_in    = 1'b0;
               rel_all_in = 1'b0;
               vidx_in    = '0;
               kidx_in    = '0;
               fu_v_in    = 1'b0;
               fp_v_in    = 1'b0;
               br_v_in    = 1'b0;
               ba_v_in    = 1'b0;
               case (req_op)
                  OP_NOTE_ON: begin
                     if (req_velocity == '0) begin
                        fsm_in = ST_FIN;
                     end else if (mode_ff inside {MODE_POLY, MODE_RETUNE, MODE_RESTART}) begin
                        vkind_in = VSCAN_FIND;
                        fsm_in   = ST_VRD;
                     end else begin
                        fsm_in = ST_PUSH;   // mode 3: stack only
                     end
                  end
                  OP_NOTE_OFF: begin
                     kkind_in = KSCAN_SEARCH;
                     fsm_in   = ST_KRD;
                  end
                  OP_ALL_OFF: begin
                     kc_in        = '0;
                     vkind_in     = VSCAN_REL;
                     rel_all_in   = 1'b1;
                     grel_in      = 1'b1;
                     grel_note_in = '0;
                     fsm_in       = ST_VRD;
                  end
                  OP_TICK: begin
                     vkind_in = VSCAN_TICK;
                     fsm_in   = ST_VRD;
                  end
                  OP_VOICE_DONE: begin
                     if (dv_ext < (VIW+VOICE_W)'(VOICES)) begin
                        vkind_in = VSCAN_DONE;
                        vidx_in  = VCW'(dv_ext);
                        fsm_in   = ST_VRD;
                     end else begin
                        fsm_in = ST_FIN;
                     end
                  end
                  default: begin
                     fsm_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_VRD: begin
            if (vkind_ff != VSCAN_DONE && vidx_ff == VCW'(VOICES)) begin
               case (vkind_ff)
                  VSCAN_FIND: fsm_in = ST_ACT;
                  VSCAN_REL:  fsm_in = grel_ff ? ST_GREL : ST_FIN;
                  default:    fsm_in = ST_FIN;
               endcase
            end else begin
               vram_re = 1'b1;
               rdv_in  = vvalid_ff[vaddr];
               fsm_in  = ST_VEV;
            end
         end

         ST_VEV: begin
            case (vkind_ff)
               VSCAN_FIND: begin
                  if (ve.vstate == VS_UNUSED && !fu_v_ff) begin
                     fu_v_in   = 1'b1;
                     fu_idx_in = vaddr;
                  end
                  if (ve.vstate == VS_PLAYING && !fp_v_ff) begin
                     fp_v_in   = 1'b1;
                     fp_idx_in = vaddr;
                     fp_age_in = ve.age;
                  end
                  if (ve.vstate == VS_RELEASING && (!br_v_ff || ve.age > br_age_ff)) begin
                     br_v_in   = 1'b1;
                     br_idx_in = vaddr;
                     br_age_in = ve.age;
                  end
                  if (!ba_v_ff || ve.age > ba_age_ff) begin
                     ba_v_in   = 1'b1;
                     ba_idx_in = vaddr;
                     ba_age_in = ve.age;
                  end
                  vidx_in = vidx_ff + 1'b1;
                  fsm_in  = ST_VRD;
               end
               VSCAN_REL: begin
                  if (ve.vstate == VS_PLAYING && (rel_all_ff || ve.key == note_ff)) begin
                     em_req = 1'b1;
                     em_res = '{action: ACT_RELEASE, voice: to_vout(vaddr),
                                note: ve.key, velocity: '0};
                     if (em_go) begin
                        vram_we    = 1'b1;
                        vram_wdata = '{vstate: VS_RELEASING, key: ve.key, age: '0};
                        vidx_in    = vidx_ff + 1'b1;
                        fsm_in     = ST_VRD;
                     end
                  end else begin
                     vidx_in = vidx_ff + 1'b1;
                     fsm_in  = ST_VRD;
                  end
               end
               VSCAN_TICK: begin
                  if (ve.vstate != VS_UNUSED && ve.age != '1) begin
                     vram_we    = 1'b1;
                     vram_wdata = '{vstate: ve.vstate, key: ve.key, age: ve.age + 1'b1};
                  end
                  vidx_in = vidx_ff + 1'b1;
                  fsm_in  = ST_VRD;
               end
               default: begin
                  if (ve.vstate == VS_RELEASING) begin
                     vram_we    = 1'b1;
                     vram_wdata = '{vstate: VS_UNUSED, key: ve.key, age: '0};
                  end
                  fsm_in = ST_FIN;
               end
            endcase
         end

         ST_ACT: begin
            em_req = 1'b1;
            if ((mode_ff == MODE_RETUNE || mode_ff == MODE_RESTART) && fp_v_ff) begin
               em_res = '{action: restart ? ACT_RESTART : ACT_RETUNE,
                          voice: to_vout(fp_idx_ff), note: wnote_ff, velocity: wvel_ff};
               if (em_go) begin
                  vram_we    = 1'b1;
                  vram_waddr = fp_idx_ff;
                  vram_wdata = '{vstate: VS_PLAYING, key: wnote_ff,
                                 age: restart ? '0 : fp_age_ff};
                  fsm_in     = (op_ff == OP_NOTE_ON) ? ST_PUSH : ST_FIN;
               end
            end else begin
               em_res = '{action: ACT_START, voice: to_vout(pick),
                          note: wnote_ff, velocity: wvel_ff};
               if (em_go) begin
                  vram_we    = 1'b1;
                  vram_waddr = pick;
                  vram_wdata = '{vstate: VS_PLAYING, key: wnote_ff, age: '0};
                  if (kc_ff == '0) begin
                     fsm_in = ST_GTRIG;
                  end else begin
                     fsm_in = (op_ff == OP_NOTE_ON) ? ST_PUSH : ST_FIN;
                  end
               end
            end
         end

         ST_GTRIG: begin
            em_req = 1'b1;
            em_res = '{action: ACT_GTRIG, voice: '0, note: wnote_ff, velocity: wvel_ff};
            if (em_go) begin
               fsm_in = (op_ff == OP_NOTE_ON) ? ST_PUSH : ST_FIN;
            end
         end

         ST_PUSH: begin
            if (kc_ff < KCW'(STACK_DEPTH)) begin
               kram_we    = 1'b1;
               kram_waddr = kc_ff[SIW-1:0];
               kram_wdata = note_ff;
               kc_in      = kc_ff + 1'b1;
            end
            fsm_in = ST_FIN;
         end

         ST_KRD: begin
            case (kkind_ff)
               KSCAN_SEARCH: begin
                  if (kidx_ff == kc_ff) begin
                     // unknown key: drop the whole stack
                     kc_in     = '0;
                     replay_in = 1'b0;
                     fsm_in    = ST_NDEC;
                  end else begin
                     kram_re = 1'b1;
                     fsm_in  = ST_KEV;
                  end
               end
               KSCAN_SHIFT: begin
                  if (kidx_ff == kc_ff) begin
                     fsm_in = ST_NDEC;
                  end else begin
                     kram_re    = 1'b1;
                     kram_raddr = kidx_p1[SIW-1:0];
                     fsm_in     = ST_KEV;
                  end
               end
               default: begin
                  kram_re    = 1'b1;
                  kram_raddr = kc_m1[SIW-1:0];
                  fsm_in     = ST_KEV;
               end
            endcase
         end

         ST_KEV: begin
            case (kkind_ff)
               KSCAN_SEARCH: begin
                  if (kram_rdata == note_ff) begin
                     kc_in = kc_m1;
                     if (kc_m1 == kidx_ff) begin
                        replay_in = 1'b1;
                        fsm_in    = ST_NDEC;
                     end else begin
                        kkind_in = KSCAN_SHIFT;
                        fsm_in   = ST_KRD;
                     end
                  end else begin
                     kidx_in = kidx_p1;
                     fsm_in  = ST_KRD;
                  end
               end
               KSCAN_SHIFT: begin
                  kram_we = 1'b1;
                  kidx_in = kidx_p1;
                  fsm_in  = ST_KRD;
               end
               default: begin
                  // replay the key now on top
                  wnote_in = kram_rdata;
                  wvel_in  = REPLAY_VEL;
                  vkind_in = VSCAN_FIND;
                  vidx_in  = '0;
                  fu_v_in  = 1'b0;
                  fp_v_in  = 1'b0;
                  br_v_in  = 1'b0;
                  ba_v_in  = 1'b0;
                  fsm_in   = ST_VRD;
               end
            endcase
         end

         ST_NDEC: begin
            vidx_in    = '0;
            rel_all_in = 1'b0;
            if (kc_ff == '0) begin
               vkind_in     = VSCAN_REL;
               grel_in      = 1'b1;
               grel_note_in = note_ff;
               fsm_in       = ST_VRD;
            end else if (mode_ff == MODE_POLY) begin
               vkind_in = VSCAN_REL;
               grel_in  = 1'b0;
               fsm_in   = ST_VRD;
            end else if ((mode_ff == MODE_RETUNE || mode_ff == MODE_RESTART) && replay_ff) begin
               kkind_in = KSCAN_TOP;
               fsm_in   = ST_KRD;
            end else begin
               fsm_in = ST_FIN;
            end
         end

         ST_GREL: begin
            em_req = 1'b1;
            em_res = '{action: ACT_GREL, voice: '0, note: grel_note_ff, velocity: '0};
            if (em_go) begin
               fsm_in = ST_FIN;
            end
         end

         ST_FIN: begin
            fin_req = 1'b1;
            if (out_free) begin
               fsm_in = ST_IDLE;
            end
         end

         default: begin
            fsm_in = ST_IDLE;
         end
      endcase

      if (vram_we) begin
         vvalid_in[vram_waddr] = 1'b1;
      end

      // holding register: an action is sent once the next one (or the end) is known
      if (em_req && em_keep && em_go) begin
         if (pend_v_ff) begin
            out_in      = pend_ff;
            out_last_in = 1'b0;
            out_v_in    = 1'b1;
         end
         pend_in    = em_res;
         pend_v_in  = 1'b1;
         res_cnt_in = res_cnt_ff + 1'b1;
      end
      if (fin_req && out_free) begin
         out_in      = pend_v_ff ? pend_ff : '{action: ACT_NONE, voice: '0,
                                               note: '0, velocity: '0};
         out_last_in = 1'b1;
         out_v_in    = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= ST_IDLE;
         mode_ff   <= MODE_POLY;
         kc_ff     <= '0;
         vvalid_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         fsm_ff    <= fsm_in;
         mode_ff   <= mode_in;
         kc_ff     <= kc_in;
         vvalid_ff <= vvalid_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      vkind_ff     <= vkind_in;
      kkind_ff     <= kkind_in;
      vidx_ff      <= vidx_in;
      kidx_ff      <= kidx_in;
      op_ff        <= op_in;
      note_ff      <= note_in;
      wnote_ff     <= wnote_in;
      wvel_ff      <= wvel_in;
      replay_ff    <= replay_in;
      grel_ff      <= grel_in;
      grel_note_ff <= grel_note_in;
      rel_all_ff   <= rel_all_in;
      fu_v_ff      <= fu_v_in;
      fu_idx_ff    <= fu_idx_in;
      fp_v_ff      <= fp_v_in;
      fp_idx_ff    <= fp_idx_in;
      fp_age_ff    <= fp_age_in;
      br_v_ff      <= br_v_in;
      br_idx_ff    <= br_idx_in;
      br_age_ff    <= br_age_in;
      ba_v_ff      <= ba_v_in;
      ba_idx_ff    <= ba_idx_in;
      ba_age_ff    <= ba_age_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
      res_cnt_ff   <= res_cnt_in;
      rdv_ff       <= rdv_in;
   end

endmodule

/* hw/rtl/sva_checker.sv */
// Port-level checks for the voice allocator, bound to the top level.
// Depends on sva_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sva_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sva_pkg::ACT_W-1:0]   rsp_action,
   input logic [sva_pkg::VOICE_W-1:0] rsp_voice,
   input logic [sva_pkg::VEL_W-1:0]   rsp_out_velocity,
   input logic                        rsp_last
);
   import sva_pkg::*;

   logic voiceless_act;
   logic silent_act;

   assign voiceless_act = rsp_action inside {ACT_NONE, ACT_GTRIG, ACT_GREL};
   assign silent_act    = rsp_action inside {ACT_RELEASE, ACT_GREL};

   // response held until taken
   `SVA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // nothing pending right after reset
   `SVA_ASSERT_NR(a_rsp_reset, clock, $past(reset) && !reset |-> !rsp_valid)

   // global actions and "none" carry voice zero
   `SVA_ASSERT(a_global_voice, clock, reset, rsp_valid && voiceless_act |-> rsp_voice == '0)

   // "none" is always alone, so it is always last
   `SVA_ASSERT(a_none_last, clock, reset, rsp_valid && rsp_action == ACT_NONE |-> rsp_last)

   // release and global release carry no velocity
   `SVA_ASSERT(a_rel_vel, clock, reset, rsp_valid && silent_act |-> rsp_out_velocity == '0)

endmodule

bind synth_voice_allocator_core sva_checker u_sva_checker (.*);

/* test/synth_voice_allocator_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for synth_voice_allocator_core: directed table and sequences, then random key traffic.
// Depends on sva_pkg and the allocator RTL; holds its own voice/key-stack predictor.
module synth_voice_allocator_core_test;
   import sva_pkg::*;

   localparam int NV = 16;
   localparam int NK = 16;
   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = '0;
   logic [NOTE_W-1:0] req_note = '0;
   logic [VEL_W-1:0] req_velocity = '0;
   logic [VOICE_W-1:0] req_done_voice = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ACT_W-1:0] rsp_action;
   logic [VOICE_W-1:0] rsp_voice;
   logic [NOTE_W-1:0] rsp_out_note;
   logic [VEL_W-1:0] rsp_out_velocity;
   logic rsp_last;

   always #10 clock = ~clock;

   synth_voice_allocator_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_note(req_note), .req_velocity(req_velocity),
      .req_done_voice(req_done_voice),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_action(rsp_action),
      .rsp_voice(rsp_voice), .rsp_out_note(rsp_out_note),
      .rsp_out_velocity(rsp_out_velocity), .rsp_last(rsp_last)
   );

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [VOICE_W-1:0] voice;
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   vel;
      logic               last;
   } action_type;

   // predictor state
   logic [1:0]        pv_state [NV];
   logic [NOTE_W-1:0] pv_key   [NV];
   logic [AGE_W-1:0]  pv_age   [NV];
   logic [NOTE_W-1:0] held_keys [NK];
   int                held_cnt;
   logic [MODE_W-1:0] cur_mode;

   action_type pending_actions[$];
   int      step_actions;
   int      errors = 0;
   int      checked = 0;
   int      idle_cycles = 0;
   bit      rsp_jitter = 1'b1;
   int      stall_left = 0;

   function automatic void post_action(logic [ACT_W-1:0] a, int v,
                                       logic [NOTE_W-1:0] n, logic [VEL_W-1:0] vl);
      action_type r;
      if (step_actions >= MAX_RESULTS) return;
      r.action = a; r.voice = v[VOICE_W-1:0]; r.note = n; r.vel = vl; r.last = 1'b0;
      pending_actions = {pending_actions, r};
      step_actions++;
   endfunction

   function automatic int first_playing();
      for (int i = 0; i < NV; i++)
         if (pv_state[i] == VS_PLAYING) return i;
      return -1;
   endfunction

   function automatic void alloc_voice(logic [NOTE_W-1:0] n, logic [VEL_W-1:0] vl);
      int pick;
      pick = -1;
      for (int i = 0; i < NV; i++)
         if (pick < 0 && pv_state[i] == VS_UNUSED) pick = i;
      if (pick < 0)
         for (int i = 0; i < NV; i++)
            if (pv_state[i] == VS_RELEASING && (pick < 0 || pv_age[i] > pv_age[pick]))
               pick = i;
      if (pick < 0) begin
         pick = 0;
         for (int i = 1; i < NV; i++)
            if (pv_age[i] > pv_age[pick]) pick = i;
      end
      pv_state[pick] = VS_PLAYING; pv_key[pick] = n; pv_age[pick] = '0;
      post_action(ACT_START, pick, n, vl);
      if (held_cnt == 0) post_action(ACT_GTRIG, 0, n, vl);
   endfunction

   function automatic void mono_note(logic [NOTE_W-1:0] n, logic [VEL_W-1:0] vl,
                                     bit restart);
      int v;
      v = first_playing();
      if (v < 0) begin
         alloc_voice(n, vl);
         return;
      end
      pv_key[v] = n;
      if (restart) begin
         pv_age[v] = '0;
         post_action(ACT_RESTART, v, n, vl);
      end else begin
         post_action(ACT_RETUNE, v, n, vl);
      end
   endfunction

   function automatic void release_one(int i);
      pv_state[i] = VS_RELEASING; pv_age[i] = '0;
      post_action(ACT_RELEASE, i, pv_key[i], '0);
   endfunction

   function automatic void release_key(logic [NOTE_W-1:0] n);
      for (int i = 0; i < NV; i++)
         if (pv_state[i] == VS_PLAYING && pv_key[i] == n) release_one(i);
   endfunction

   // Works out every action one request causes and queues them.
   function automatic void predict_request(logic [OP_W-1:0] op, logic [NOTE_W-1:0] n,
                                           logic [VEL_W-1:0] vl, logic [VOICE_W-1:0] dv);
      int found;
      bit replay;
      step_actions = 0;
      case (op)
         OP_NOTE_ON: if (vl != 0) begin
            if (cur_mode == MODE_POLY) alloc_voice(n, vl);
            else if (cur_mode == MODE_RETUNE) mono_note(n, vl, 1'b0);
            else if (cur_mode == MODE_RESTART) mono_note(n, vl, 1'b1);
            if (held_cnt < NK) begin
               held_keys[held_cnt] = n;
               held_cnt++;
            end
         end
         OP_NOTE_OFF: begin
            replay = 1'b0;
            found = held_cnt;
            for (int i = held_cnt - 1; i >= 0; i--)
               if (held_keys[i] == n) found = i;
            if (found == held_cnt) begin
               held_cnt = 0;
            end else begin
               held_cnt--;
               if (held_cnt == found) replay = 1'b1;
               else for (int i = found; i < held_cnt; i++) held_keys[i] = held_keys[i+1];
            end
            if (held_cnt == 0) begin
               release_key(n);
               post_action(ACT_GREL, 0, n, '0);
            end else if (cur_mode == MODE_POLY) begin
               release_key(n);
            end else if (cur_mode == MODE_RETUNE || cur_mode == MODE_RESTART) begin
               if (replay) mono_note(held_keys[held_cnt-1], REPLAY_VEL, 1'b0);
            end
         end
         OP_ALL_OFF: begin
            for (int i = 0; i < NV; i++)
               if (pv_state[i] == VS_PLAYING) release_one(i);
            held_cnt = 0;
            post_action(ACT_GREL, 0, '0, '0);
         end
         OP_TICK:
            for (int i = 0; i < NV; i++)
               if (pv_state[i] != VS_UNUSED && pv_age[i] != '1) pv_age[i]++;
         OP_VOICE_DONE:
            if (pv_state[dv] == VS_RELEASING) begin
               pv_state[dv] = VS_UNUSED; pv_age[dv] = '0;
            end
         default: ;
      endcase
      if (step_actions == 0) post_action(ACT_NONE, 0, '0, '0);
      pending_actions[$].last = 1'b1;
   endfunction

   // response side: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_actions.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response: act %0d v %0d n %0d vel %0d l %0b",
                           rsp_action, rsp_voice, rsp_out_note, rsp_out_velocity, rsp_last);
            end else begin
               action_type e;
               e = pending_actions.pop_front();
               checked++;
               if (e.action !== rsp_action || e.voice !== rsp_voice ||
                   e.note !== rsp_out_note || e.vel !== rsp_out_velocity ||
                   e.last !== rsp_last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                              e.action, e.voice, e.note, e.vel, e.last, rsp_action,
                              rsp_voice, rsp_out_note, rsp_out_velocity, rsp_last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_jitter && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no request or response accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d responses outstanding", pending_actions.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [NOTE_W-1:0] n,
                               logic [VEL_W-1:0] vl, logic [VOICE_W-1:0] dv, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 17)) @(posedge clock);
      req_valid <= 1'b1; req_op <= op; req_note <= n;
      req_velocity <= vl; req_done_voice <= dv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(op, n, vl, dv);
      req_valid <= 1'b0;
      // ready goes low once a request is taken, so this costs nothing
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (2 * NV + 20) @(posedge clock);
   endtask

   task automatic set_mode(logic [MODE_W-1:0] m);
      drain();
      csr_wr_en <= 1'b1; csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   // directed rows; expected action checked at a glance where obvious
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   vel;
      logic [VOICE_W-1:0] dv;
      bit                 has_quick;
      logic [ACT_W-1:0]   quick_act;
   } row_type;

   row_type directed [] = '{
      '{OP_TICK,       7'd0,   7'd0,   4'd0,  1'b1, ACT_NONE},
      '{OP_NOTE_ON,    7'd60,  7'd0,   4'd0,  1'b1, ACT_NONE},    // zero velocity
      '{OP_NOTE_ON,    7'd0,   7'd127, 4'd0,  1'b1, ACT_START},
      '{OP_NOTE_ON,    7'd127, 7'd1,   4'd15, 1'b1, ACT_START},
      '{OP_TICK,       7'd0,   7'd0,   4'd0,  1'b0, ACT_NONE},
      '{OP_NOTE_OFF,   7'd0,   7'd0,   4'd0,  1'b0, ACT_NONE},    // non-top key
      '{OP_NOTE_OFF,   7'd99,  7'd0,   4'd0,  1'b0, ACT_NONE},    // unknown key clears stack
      '{OP_VOICE_DONE, 7'd0,   7'd0,   4'd0,  1'b1, ACT_NONE},
      '{OP_VOICE_DONE, 7'd0,   7'd0,   4'd15, 1'b1, ACT_NONE},    // not releasing
      '{OP_VOICE_DONE, 7'd0,   7'd0,   4'd1,  1'b1, ACT_NONE},
      '{3'd5,          7'd127, 7'd127, 4'd15, 1'b1, ACT_NONE},
      '{3'd7,          7'd0,   7'd0,   4'd0,  1'b1, ACT_NONE},
      '{OP_ALL_OFF,    7'd0,   7'd0,   4'd0,  1'b0, ACT_NONE},
      '{OP_NOTE_ON,    7'd85,  7'd42,  4'd10, 1'b1, ACT_START}
   };

   initial begin
      int first_idx;
      for (int i = 0; i < NV; i++) begin
         pv_state[i] = VS_UNUSED; pv_key[i] = '0; pv_age[i] = '0;
      end
      held_cnt = 0;
      cur_mode = MODE_POLY;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_request(directed[i].op, directed[i].note, directed[i].vel,
                      directed[i].dv, 1'b1);
         // this request's actions are the last ones queued
         first_idx = pending_actions.size() - step_actions;
         if (directed[i].has_quick &&
             pending_actions[first_idx].action !== directed[i].quick_act) begin
            errors++;
            $display("directed row %0d: predictor gives act %0d, table says %0d",
                     i, pending_actions[first_idx].action, directed[i].quick_act);
         end
      end

      // overfill voices and stack in poly mode: stealing and full stack
      for (int i = 0; i < NV + 3; i++) begin
         send_request(OP_NOTE_ON, 7'(i * 5 + 1), 7'($urandom_range(1, 127)), '0, 1'b0);
         if (i % 4 == 0) send_request(OP_TICK, '0, '0, '0, 1'b0);
      end
      send_request(OP_ALL_OFF, '0, '0, '0, 1'b1);

      // mono retune with key replay at low velocity
      set_mode(MODE_RETUNE);
      send_request(OP_NOTE_ON, 7'd40, 7'd90, '0, 1'b1);
      send_request(OP_NOTE_ON, 7'd44, 7'd91, '0, 1'b1);
      send_request(OP_NOTE_OFF, 7'd44, '0, '0, 1'b1);
      send_request(OP_NOTE_OFF, 7'd40, '0, '0, 1'b1);
      set_mode(MODE_RESTART);
      send_request(OP_NOTE_ON, 7'd50, 7'd10, '0, 1'b1);
      send_request(OP_NOTE_ON, 7'd52, 7'd11, '0, 1'b1);
      send_request(OP_NOTE_OFF, 7'd52, '0, '0, 1'b1);
      send_request(OP_ALL_OFF, '0, '0, '0, 1'b1);
      set_mode(2'd3);   // unassigned mode: keys pushed, voices untouched
      send_request(OP_NOTE_ON, 7'd30, 7'd60, '0, 1'b1);
      send_request(OP_NOTE_ON, 7'd31, 7'd60, '0, 1'b1);
      send_request(OP_NOTE_OFF, 7'd30, '0, '0, 1'b1);
      send_request(OP_NOTE_OFF, 7'd31, '0, '0, 1'b1);

      // random: mostly note on/off on a small key set so offs hit held keys
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) rsp_jitter = 1'b0;
         set_mode(phase == 3 ? MODE_POLY : MODE_W'(phase));
         for (int k = 0; k < 12; k++) begin
            int pick;
            logic [NOTE_W-1:0] key;
            pick = $urandom_range(0, 99);
            key = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom)
                                               : NOTE_W'(60 + $urandom_range(0, 7));
            if (pick < 40)
               send_request(OP_NOTE_ON, key, VEL_W'($urandom_range(0, 127)), '0, phase != 3);
            else if (pick < 70)
               send_request(OP_NOTE_OFF, key, VEL_W'($urandom), VOICE_W'($urandom), phase != 3);
            else if (pick < 82)
               send_request(OP_TICK, NOTE_W'($urandom), '0, '0, phase != 3);
            else if (pick < 94)
               send_request(OP_VOICE_DONE, '0, '0, VOICE_W'($urandom), phase != 3);
            else if (pick < 97)
               send_request(OP_ALL_OFF, '0, '0, '0, phase != 3);
            else
               send_request(OP_W'($urandom_range(5, 7)), NOTE_W'($urandom),
                            VEL_W'($urandom), '0, phase != 3);
         end
      end

      drain();
      $display("checked %0d responses over all four mode settings, stealing and key replay",
               checked);
      if (errors == 0 && pending_actions.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, pending_actions.size());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
